// ===== hw/rtl/mi3_pkg.sv =====
// Shared constants for the 3x3 matrix inverse core.
package mi3_pkg;

    localparam int DIM      = 3;
    localparam int NUM_ELEM = DIM * DIM;

endpackage

// ===== hw/rtl/mi3_if.sv =====
// Valid/ready channel interfaces for matrix beats and inverse beats.
interface mi3_in_if #(parameter int ELEMENT_WIDTH = 32);
    logic valid;
    logic ready;
    logic signed [ELEMENT_WIDTH-1:0] m00, m01, m02, m10, m11, m12, m20, m21, m22;

    modport source (output valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
                    input ready);
    modport sink   (input valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
                    output ready);
endinterface

interface mi3_out_if #(parameter int ELEMENT_WIDTH = 32);
    logic valid;
    logic ready;
    logic signed [ELEMENT_WIDTH-1:0] r00, r01, r02, r10, r11, r12, r20, r21, r22;
    logic singular;
    logic overflow;

    modport source (output valid, r00, r01, r02, r10, r11, r12, r20, r21, r22,
                    singular, overflow, input ready);
    modport sink   (input valid, r00, r01, r02, r10, r11, r12, r20, r21, r22,
                    singular, overflow, output ready);
endinterface

// ===== hw/rtl/mi3_cof.sv =====
// Two-stage cofactor unit: 2x2 minor products, then their differences.
module mi3_cof
    import mi3_pkg::*;
#(
    parameter int W = 32
)(
    input  logic                  clk,
    input  logic                  en,
    input  logic signed [W-1:0]   m      [NUM_ELEM],
    output logic signed [2*W:0]   cof    [NUM_ELEM],
    output logic signed [W-1:0]   row0   [DIM]
);

    logic signed [2*W-1:0] pa_reg [NUM_ELEM];
    logic signed [2*W-1:0] pb_reg [NUM_ELEM];
    logic signed [W-1:0]   row0_d1_reg [DIM];
    logic signed [W-1:0]   row0_d2_reg [DIM];
    logic signed [2*W:0]   cof_reg [NUM_ELEM];

    for (genvar j = 0; j < DIM; j++) begin : g_row
        for (genvar i = 0; i < DIM; i++) begin : g_col
            localparam int J1 = (j + 1) % DIM;
            localparam int J2 = (j + 2) % DIM;
            localparam int I1 = (i + 1) % DIM;
            localparam int I2 = (i + 2) % DIM;
            localparam int C  = j * DIM + i;
            logic signed [2*W-1:0] pa_next, pb_next;
            logic signed [2*W:0]   cof_next;

            assign pa_next  = m[J1*DIM+I1] * m[J2*DIM+I2];
            assign pb_next  = m[J1*DIM+I2] * m[J2*DIM+I1];
            assign cof_next = (2*W+1)'(pa_reg[C]) - (2*W+1)'(pb_reg[C]);

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    pa_reg[C]  <= pa_next;
                    pb_reg[C]  <= pb_next;
                    cof_reg[C] <= cof_next;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < DIM; k++)
            begin
                row0_d1_reg[k] <= m[k];
                row0_d2_reg[k] <= row0_d1_reg[k];
            end
        end
    end

    assign cof  = cof_reg;
    assign row0 = row0_d2_reg;

endmodule

// ===== hw/rtl/mi3_det.sv =====
// Two-stage determinant: split partial products, then the signed sum.
module mi3_det
    import mi3_pkg::*;
#(
    parameter int W = 32
)(
    input  logic                  clk,
    input  logic                  en,
    input  logic signed [W-1:0]   row0  [DIM],
    input  logic signed [2*W:0]   cof0  [DIM],
    output logic signed [3*W+2:0] det
);

    localparam int DW = 3 * W + 3;

    logic signed [2*W:0]   lo_reg [DIM];
    logic signed [2*W:0]   hi_reg [DIM];
    logic signed [DW-1:0]  det_reg;
    logic signed [DW-1:0]  det_next;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < DIM; k++)
            begin
                lo_reg[k] <= row0[k] * $signed({1'b0, cof0[k][W-1:0]});
                hi_reg[k] <= row0[k] * $signed(cof0[k][2*W:W]);
            end
            det_reg <= det_next;
        end
    end

    always_comb
    begin
        det_next = '0;
        for (int k = 0; k < DIM; k++)
        begin
            det_next = det_next + (DW'(hi_reg[k]) <<< W) + DW'(lo_reg[k]);
        end
    end

    assign det = det_reg;

endmodule

// ===== hw/rtl/mi3_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, with saturation.
module mi3_div #(
    parameter int W  = 32,
    parameter int XW = 200,
    parameter int DM = 100
)(
    input  logic                clk,
    input  logic                en,
    input  logic [XW-1:0]       num,
    input  logic [DM-1:0]       den,
    input  logic                neg,
    input  logic                pre_ovf,
    output logic signed [W-1:0] res,
    output logic                ovf
);

    logic [XW-1:0] rem_reg  [W+1];
    logic [DM-1:0] den_reg  [W+1];
    logic [W-1:0]  q_reg    [W+1];
    logic          neg_reg  [W+1];
    logic          povf_reg [W+1];
    logic signed [W-1:0] res_reg;
    logic          ovf_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0]  <= num;
            den_reg[0]  <= den;
            q_reg[0]    <= '0;
            neg_reg[0]  <= neg;
            povf_reg[0] <= pre_ovf;
        end
    end

    for (genvar s = 0; s < W; s++) begin : g_stage
        localparam int K = W - 1 - s;
        logic [XW-1:0] dsh;
        logic          ge;

        assign dsh = XW'(den_reg[s]) << K;
        assign ge  = rem_reg[s] >= dsh;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[s+1]  <= ge ? rem_reg[s] - dsh : rem_reg[s];
                den_reg[s+1]  <= den_reg[s];
                q_reg[s+1]    <= q_reg[s] | (ge ? (W'(1) << K) : '0);
                neg_reg[s+1]  <= neg_reg[s];
                povf_reg[s+1] <= povf_reg[s];
            end
        end
    end

    logic [W-1:0] lim, mag;
    logic         sat;

    always_comb
    begin
        lim = neg_reg[W] ? (W'(1) << (W - 1)) : ((W'(1) << (W - 1)) - W'(1));
        sat = povf_reg[W] || (q_reg[W] > lim);
        mag = sat ? lim : q_reg[W];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            res_reg <= (neg_reg[W] && mag != '0) ? $signed(-mag) : $signed(mag);
            ovf_reg <= sat;
        end
    end

    assign res = res_reg;
    assign ovf = ovf_reg;

endmodule

// ===== hw/rtl/matrix_inverse_3x3_core.sv =====
// Path: cofactors, determinant, divider input register, divider stages, output.
// Throughput: one matrix per cycle; the whole pipeline holds on output stall.
// The divider spends one stage per quotient bit, which sets the depth.
// rst_n (async, active low) clears all valid bits; data registers are not reset.
// A zero determinant is divided as 2^(3*FRAC_BITS), which yields the adjugate.
module matrix_inverse_3x3_core
    import mi3_pkg::*;
#(
    parameter int ELEMENT_WIDTH = 32,
    parameter int FRAC_BITS     = 16
)(
    input  logic       clk,
    input  logic       rst_n,
    mi3_in_if.sink     mat_in,
    mi3_out_if.source  inv_out
);

    localparam int W   = ELEMENT_WIDTH;
    localparam int F   = FRAC_BITS;
    localparam int CW  = 2 * W + 1;             // cofactor width, signed
    localparam int DW  = 3 * W + 3;             // determinant width, signed
    localparam int DM  = (DW > 3 * F + 1) ? DW : 3 * F + 1;
    localparam int NW  = 2 * W + 2 * F;         // shifted numerator magnitude
    localparam int XW  = ((NW > DM + W) ? NW : DM + W) + 1;
    localparam int LAT = W + 6;

    // Global advance: move every stage when the output slot is free or taken.
    logic en;
    logic [LAT-1:0] vld_reg;
    logic [W+1:0]   sing_reg;

    assign en           = !vld_reg[LAT-1] || inv_out.ready;
    assign mat_in.ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[LAT-2:0], mat_in.valid};
        end
    end

    // Gather the matrix beat into an array, row major.
    logic signed [W-1:0] m [NUM_ELEM];
    assign m[0] = mat_in.m00;
    assign m[1] = mat_in.m01;
    assign m[2] = mat_in.m02;
    assign m[3] = mat_in.m10;
    assign m[4] = mat_in.m11;
    assign m[5] = mat_in.m12;
    assign m[6] = mat_in.m20;
    assign m[7] = mat_in.m21;
    assign m[8] = mat_in.m22;

    // Stages 1-2: cofactors.
    logic signed [CW-1:0] cof  [NUM_ELEM];
    logic signed [W-1:0]  row0 [DIM];

    mi3_cof #(.W(W)) u_cof (
        .clk  (clk),
        .en   (en),
        .m    (m),
        .cof  (cof),
        .row0 (row0)
    );

    // Stages 3-4: determinant along row 0; carry cofactors alongside.
    logic signed [CW-1:0] cof0 [DIM];
    logic signed [DW-1:0] det;
    logic signed [CW-1:0] cof_d1_reg [NUM_ELEM];
    logic signed [CW-1:0] cof_d2_reg [NUM_ELEM];

    assign cof0[0] = cof[0];
    assign cof0[1] = cof[1];
    assign cof0[2] = cof[2];

    mi3_det #(.W(W)) u_det (
        .clk  (clk),
        .en   (en),
        .row0 (row0),
        .cof0 (cof0),
        .det  (det)
    );

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cof_d1_reg <= cof;
            cof_d2_reg <= cof_d1_reg;
        end
    end

    // Stage 5 setup: magnitudes, substitute divisor, early overflow test.
    logic          sing;
    logic [DM-1:0] den;
    logic [DW-1:0] det_mag;

    assign sing    = (det == '0);
    assign det_mag = det[DW-1] ? DW'(-det) : DW'(det);
    assign den     = sing ? (DM'(1) << (3 * F)) : DM'(det_mag);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sing_reg <= {sing_reg[W:0], sing};
        end
    end

    logic signed [W-1:0] res [NUM_ELEM];
    logic [NUM_ELEM-1:0] ovf;

    for (genvar i = 0; i < DIM; i++) begin : g_ri
        for (genvar j = 0; j < DIM; j++) begin : g_rj
            // Result (i,j) divides cofactor (j,i): the adjugate transpose.
            localparam int C = j * DIM + i;
            logic [CW-1:0] cmag;
            logic [XW-1:0] num;
            logic          neg, pre_ovf;

            assign cmag    = cof_d2_reg[C][CW-1] ? CW'(-cof_d2_reg[C])
                                                 : CW'(cof_d2_reg[C]);
            assign num     = XW'(cmag) << (2 * F);
            assign neg     = cof_d2_reg[C][CW-1] ^ (det[DW-1] && !sing);
            assign pre_ovf = num >= (XW'(den) << W);

            mi3_div #(.W(W), .XW(XW), .DM(DM)) u_div (
                .clk     (clk),
                .en      (en),
                .num     (num),
                .den     (den),
                .neg     (neg),
                .pre_ovf (pre_ovf),
                .res     (res[i*DIM+j]),
                .ovf     (ovf[i*DIM+j])
            );
        end
    end

    // Drive the inverse beat straight from the divider output registers.
    assign inv_out.valid    = vld_reg[LAT-1];
    assign inv_out.r00      = res[0];
    assign inv_out.r01      = res[1];
    assign inv_out.r02      = res[2];
    assign inv_out.r10      = res[3];
    assign inv_out.r11      = res[4];
    assign inv_out.r12      = res[5];
    assign inv_out.r20      = res[6];
    assign inv_out.r21      = res[7];
    assign inv_out.r22      = res[8];
    assign inv_out.singular = sing_reg[W+1];
    assign inv_out.overflow = |ovf;

endmodule

// ===== hw/rtl/mi3_checker.sv =====
// Port-level checker for the matrix inverse core, with its bind.
module mi3_checker (
    input logic clk,
    input logic rst_n,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready,
    input logic singular,
    input logic overflow
);

    a_ready_follows_out: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready == (!out_valid || out_ready))
        else $error("input ready does not track output slot");

    a_valid_drops_on_take: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(out_valid) |-> $past(out_ready))
        else $error("output beat dropped without handshake");

    a_stall_holds_flags: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(singular) && $stable(overflow))
        else $error("stalled output beat changed");

endmodule

bind matrix_inverse_3x3_core mi3_checker u_mi3_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (mat_in.ready),
    .out_valid (inv_out.valid),
    .out_ready (inv_out.ready),
    .singular  (inv_out.singular),
    .overflow  (inv_out.overflow)
);

// ===== dv/matrix_inverse_3x3_core_test.sv =====
`timescale 1ns / 100ps
// Testbench for the 3x3 fixed-point matrix inverse core: directed and random matrices.
module matrix_inverse_3x3_core_test
    import mi3_pkg::*;
();

    localparam int EW   = 32;
    localparam int FB   = 16;
    localparam int LAT  = EW + 6;
    localparam longint LIMIT = 400000;

    typedef logic signed [EW-1:0] elem_t;

    typedef struct {
        elem_t r [NUM_ELEM];
        logic  singular;
        logic  overflow;
    } inverse_t;

    logic clk;
    logic rst_n;

    mi3_in_if  #(.ELEMENT_WIDTH(EW)) mat_in ();
    mi3_out_if #(.ELEMENT_WIDTH(EW)) inv_out ();

    matrix_inverse_3x3_core #(.ELEMENT_WIDTH(EW), .FRAC_BITS(FB)) u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .mat_in  (mat_in.sink),
        .inv_out (inv_out.source)
    );

    inverse_t expected_inverses[$];
    int       error_count;
    longint   cycle_count;
    bit       sender_idle_on;
    bit       receiver_idle_on;
    int       stall_left;

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // Saturate an exact quotient into the element width; flag overflow.
    function automatic elem_t saturate_elem(input logic signed [255:0] q, inout logic ovf);
        logic signed [255:0] hi;
        logic signed [255:0] lo;
        hi = (256'sd1 <<< (EW - 1)) - 1;
        lo = -(256'sd1 <<< (EW - 1));
        if (q > hi)
        begin
            ovf = 1'b1;
            return hi[EW-1:0];
        end
        if (q < lo)
        begin
            ovf = 1'b1;
            return lo[EW-1:0];
        end
        return q[EW-1:0];
    endfunction

    // Compute the inverse through the adjugate with exact wide integers.
    function automatic inverse_t compute_inverse(input elem_t m [NUM_ELEM]);
        inverse_t res;
        logic signed [255:0] a [DIM][DIM];
        logic signed [255:0] cof [DIM][DIM];
        logic signed [255:0] det;
        logic signed [255:0] num;
        logic signed [255:0] q;
        int j1, j2, i1, i2;
        for (int r = 0; r < DIM; r++)
            for (int c = 0; c < DIM; c++)
                a[r][c] = 256'(m[r*DIM + c]);
        for (int j = 0; j < DIM; j++)
            for (int i = 0; i < DIM; i++)
            begin
                j1 = (j + 1) % DIM;
                j2 = (j + 2) % DIM;
                i1 = (i + 1) % DIM;
                i2 = (i + 2) % DIM;
                cof[j][i] = a[j1][i1] * a[j2][i2] - a[j1][i2] * a[j2][i1];
            end
        det = 0;
        for (int j = 0; j < DIM; j++)
            det += a[0][j] * cof[0][j];
        res.singular = (det == 0);
        res.overflow = 1'b0;
        for (int i = 0; i < DIM; i++)
            for (int j = 0; j < DIM; j++)
            begin
                num = cof[j][i];
                // Signed division truncates toward zero, as the block must.
                if (res.singular)
                    q = num / (256'sd1 <<< FB);
                else
                    q = (num <<< (2 * FB)) / det;
                res.r[i*DIM + j] = saturate_elem(q, res.overflow);
            end
        return res;
    endfunction

    // Drop valid and idle for a burst now and then, or never when idling is off.
    task automatic maybe_idle(input bit on);
        if (on && $urandom_range(0, 3) == 0)
        begin
            mat_in.valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clk);
        end
    endtask

    // Send one matrix beat and queue its expected inverse.
    task automatic send_matrix(input elem_t m [NUM_ELEM]);
        maybe_idle(sender_idle_on);
        mat_in.valid <= 1'b1;
        mat_in.m00 <= m[0]; mat_in.m01 <= m[1]; mat_in.m02 <= m[2];
        mat_in.m10 <= m[3]; mat_in.m11 <= m[4]; mat_in.m12 <= m[5];
        mat_in.m20 <= m[6]; mat_in.m21 <= m[7]; mat_in.m22 <= m[8];
        @(posedge clk);
        while (!mat_in.ready)
            @(posedge clk);
        expected_inverses.push_back(compute_inverse(m));
    endtask

    function automatic elem_t rand_elem(input int mode);
        case (mode)
            0: return elem_t'($urandom);
            1: return elem_t'($signed($urandom_range(0, 8 << FB)) - (4 << FB));
            2: return elem_t'($signed($urandom_range(0, 64)) - 32);
            default:
            begin
                case ($urandom_range(0, 4))
                    0: return {1'b1, {(EW-1){1'b0}}};
                    1: return {1'b0, {(EW-1){1'b1}}};
                    2: return '0;
                    3: return elem_t'(1 << FB);
                    default: return '1;
                endcase
            end
        endcase
    endfunction

    task automatic test_directed();
        elem_t m [NUM_ELEM];
        // identity
        foreach (m[k]) m[k] = (k % 4 == 0) ? elem_t'(1 << FB) : '0;
        send_matrix(m);
        // all zero: singular, adjugate zero
        foreach (m[k]) m[k] = '0;
        send_matrix(m);
        // ramp 1 to 9, rank two: singular with a nonzero adjugate
        foreach (m[k]) m[k] = elem_t'((k + 1) << FB);
        send_matrix(m);
        // rank two singular matrix
        m = '{elem_t'(1 << FB), '0, '0, '0, elem_t'(1 << FB), '0, '0, '0, '0};
        send_matrix(m);
        // all most negative and all most positive
        foreach (m[k]) m[k] = {1'b1, {(EW-1){1'b0}}};
        send_matrix(m);
        foreach (m[k]) m[k] = {1'b0, {(EW-1){1'b1}}};
        send_matrix(m);
        // diagonal extremes: huge and tiny inverses (overflow)
        foreach (m[k]) m[k] = '0;
        m[0] = 1; m[4] = 1; m[8] = 1;
        send_matrix(m);
        m[0] = {1'b1, {(EW-1){1'b0}}}; m[4] = {1'b0, {(EW-1){1'b1}}}; m[8] = '1;
        send_matrix(m);
        // negative diagonal, scaled
        foreach (m[k]) m[k] = '0;
        m[0] = -elem_t'(2 << FB); m[4] = -elem_t'(1 << FB); m[8] = elem_t'(4 << FB);
        send_matrix(m);
        // permutation
        m = '{'0, elem_t'(1 << FB), '0, '0, '0, elem_t'(1 << FB), elem_t'(1 << FB), '0, '0};
        send_matrix(m);
        // general small integers, negative results truncated toward zero
        m = '{elem_t'(3 << FB), elem_t'(-7), elem_t'(5), elem_t'(1 << FB), elem_t'(2 << FB),
              elem_t'(-(1 << FB)), elem_t'(9), elem_t'(-(3 << FB)), elem_t'(7 << FB)};
        send_matrix(m);
        repeat (12)
        begin
            foreach (m[k]) m[k] = rand_elem(3);
            send_matrix(m);
        end
    endtask

    task automatic test_random(input int count);
        elem_t m [NUM_ELEM];
        int mode;
        for (int n = 0; n < count; n++)
        begin
            mode = $urandom_range(0, 9);
            foreach (m[k])
                m[k] = rand_elem(mode < 3 ? 0 : mode < 7 ? 1 : mode < 9 ? 2 : 3);
            // Now and then force a dependent row to hit the singular path.
            if ($urandom_range(0, 7) == 0)
                for (int c = 0; c < DIM; c++)
                    m[2*DIM + c] = m[c];
            send_matrix(m);
        end
    endtask

    // Receiver: stall in random bursts while idling is on.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inv_out.ready <= 1'b0;
            stall_left    <= 0;
        end
        else if (receiver_idle_on && stall_left > 0)
        begin
            inv_out.ready <= 1'b0;
            stall_left    <= stall_left - 1;
        end
        else if (receiver_idle_on && $urandom_range(0, 7) == 0)
        begin
            inv_out.ready <= 1'b0;
            stall_left    <= $urandom_range(0, 17);
        end
        else
            inv_out.ready <= 1'b1;
    end

    // Check each inverse beat against the oldest expectation.
    always @(posedge clk)
    begin
        inverse_t exp_inv;
        elem_t    got [NUM_ELEM];
        if (rst_n && inv_out.valid && inv_out.ready)
        begin
            if (expected_inverses.size() == 0)
            begin
                $error("unexpected inverse beat");
                error_count++;
            end
            else
            begin
                exp_inv = expected_inverses.pop_front();
                got = '{inv_out.r00, inv_out.r01, inv_out.r02, inv_out.r10, inv_out.r11,
                        inv_out.r12, inv_out.r20, inv_out.r21, inv_out.r22};
                for (int k = 0; k < NUM_ELEM; k++)
                    if (got[k] !== exp_inv.r[k])
                    begin
                        $error("r%0d%0d: expected %0d, got %0d", k / DIM, k % DIM,
                               exp_inv.r[k], got[k]);
                        error_count++;
                    end
                if (inv_out.singular !== exp_inv.singular)
                begin
                    $error("singular: expected %0b, got %0b", exp_inv.singular,
                           inv_out.singular);
                    error_count++;
                end
                if (inv_out.overflow !== exp_inv.overflow)
                begin
                    $error("overflow: expected %0b, got %0b", exp_inv.overflow,
                           inv_out.overflow);
                    error_count++;
                end
            end
        end
    end

    // Watchdog: end the run as failed once the cycle count passes LIMIT.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial
    begin
        error_count      = 0;
        cycle_count      = 0;
        sender_idle_on   = 1'b1;
        receiver_idle_on = 1'b1;
        rst_n            = 1'b0;
        mat_in.valid     = 1'b0;
        {mat_in.m00, mat_in.m01, mat_in.m02} = '0;
        {mat_in.m10, mat_in.m11, mat_in.m12} = '0;
        {mat_in.m20, mat_in.m21, mat_in.m22} = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random(1300);
        // Drop all idling for the last stretch to run at full rate.
        sender_idle_on   = 1'b0;
        receiver_idle_on = 1'b0;
        test_random(300);
        mat_in.valid <= 1'b0;

        while (expected_inverses.size() != 0)
            @(posedge clk);
        repeat (2 * LAT) @(posedge clk);

        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
